[src/rcpa_pkg.sv]
package rcpa_pkg;

   localparam int unsigned LINE_BUFFER_BYTES_DEFAULT = 512;

   localparam logic [4:0] KW_A_LEN = 5'd14;
   localparam logic [4:0] KW_B_LEN = 5'd21;

   // floor((2^63 - 1) / 10); the last digit then decides the range
   localparam logic [63:0] MAG_LIMIT_DIV10 = 64'd922337203685477580;
   localparam logic [3:0]  POS_LAST_DIGIT_MAX = 4'd7;
   localparam logic [3:0]  NEG_LAST_DIGIT_MAX = 4'd8;

   localparam logic [13:0] KBPS_SCALE = 14'd1000;
   localparam logic signed [63:0] RATE_FLOOR = 64'sd1000;

   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_LF    = 8'h0A;
   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_VT    = 8'h0B;
   localparam logic [7:0] CHR_FF    = 8'h0C;
   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      PH_KEY,
      PH_BLANK,
      PH_SIGN,
      PH_DIGITS,
      PH_TAIL,
      PH_BAD,
      PH_UNKNOWN
   } phase_type;

   typedef enum logic [3:0] {
      ST_KEPT        = 4'd0,
      ST_IGNORED     = 4'd1,
      ST_ACCEPTED    = 4'd2,
      ST_UNKNOWN     = 4'd3,
      ST_INVALID     = 4'd4,
      ST_OVERFLOW    = 4'd5,
      ST_NOT_VIDEO   = 4'd6,
      ST_NO_CHANGE   = 4'd7,
      ST_RATE_UNSET  = 4'd8,
      ST_APPLIED     = 4'd9
   } status_type;

   typedef enum logic {
      MODE_BYTE  = 1'b0,
      MODE_APPLY = 1'b1
   } mode_type;

   // short keyword: "videorateadapt"
   function automatic logic [7:0] kw_a_char(input logic [4:0] pos);
      logic [7:0] ch;
      case (pos)
         5'd0:  ch = "v";
         5'd1:  ch = "i";
         5'd2:  ch = "d";
         5'd3:  ch = "e";
         5'd4:  ch = "o";
         5'd5:  ch = "r";
         5'd6:  ch = "a";
         5'd7:  ch = "t";
         5'd8:  ch = "e";
         5'd9:  ch = "a";
         5'd10: ch = "d";
         5'd11: ch = "a";
         5'd12: ch = "p";
         5'd13: ch = "t";
         default: ch = CHR_NUL;
      endcase
      return ch;
   endfunction

   // long keyword: prefixed form of the short one
   function automatic logic [7:0] kw_b_char(input logic [4:0] pos);
      logic [7:0] ch;
      case (pos)
         5'd0:  ch = "s";
         5'd1:  ch = "a";
         5'd2:  ch = "g";
         5'd3:  ch = "e";
         5'd4:  ch = "t";
         5'd5:  ch = "v";
         5'd6:  ch = "_";
         default: ch = kw_a_char(pos - 5'd7);
      endcase
      return ch;
   endfunction

endpackage

[src/rate_command_parser_accumulator.sv]
// channel | ports                                   | direction | accepted when
// req     | req_valid, req_ready, req_<field>       | in        | req_valid & req_ready
// rsp     | rsp_valid, rsp_ready, rsp_<field>       | out       | rsp_valid & rsp_ready
//
// each item yields one result in the cycle after it is taken; a new item can be taken
// every cycle rsp_ready allows, set by the single output register stage and line state.
// reset (synchronous, active high) clears the line parser, the running total and
// the output valid; payload registers are not reset.
// req_ready is low only while a result is held and rsp_ready is low.
module rate_command_parser_accumulator #(
   parameter int unsigned LINE_BUFFER_BYTES = rcpa_pkg::LINE_BUFFER_BYTES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [7:0]         req_char_code,
   input  logic signed [63:0] req_current_rate,
   input  logic signed [63:0] req_current_max_rate,
   input  logic signed [63:0] req_applied_so_far,
   input  logic               req_is_video,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_status,
   output logic signed [63:0] rsp_running_total,
   output logic signed [63:0] rsp_adjusted_rate,
   output logic signed [63:0] rsp_new_max_rate,
   output logic signed [63:0] rsp_new_applied
);

   localparam int unsigned LEN_W = $clog2(LINE_BUFFER_BYTES);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_BUFFER_BYTES - 1);

   // line state
   logic [LEN_W-1:0]     line_length_ff, line_length_in;
   rcpa_pkg::phase_type  phase_ff, phase_in;
   logic [4:0]           kw_pos_ff, kw_pos_in;
   logic [1:0]           kw_cand_ff, kw_cand_in;
   logic                 neg_ff, neg_in;
   logic [63:0]          mag_ff, mag_in;
   logic [63:0]          scaled_ff, scaled_in;   // magnitude times 1000, kept alongside
   logic                 range_err_ff, range_err_in;
   logic [63:0]          total_ff, total_in;

   // result register
   logic                 out_valid_ff, out_valid_in;
   rcpa_pkg::status_type status_ff, status_in;
   logic [63:0]          rate_ff, rate_in;
   logic [63:0]          max_ff, max_in;
   logic [63:0]          applied_ff, applied_in;

   logic        accept;
   logic [7:0]  ch;
   logic        is_digit;
   logic [3:0]  digit;
   logic [3:0]  last_max;
   logic        digit_over;
   logic [1:0]  cand;
   logic [4:0]  pos_next;
   logic [63:0] signed_scaled;
   logic [63:0] rate_sum;
   logic [63:0] max_sum;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign ch        = req_char_code;
   assign is_digit  = (ch >= rcpa_pkg::CHR_ZERO) && (ch <= rcpa_pkg::CHR_NINE);
   assign digit     = 4'(ch - rcpa_pkg::CHR_ZERO);
   assign last_max  = neg_ff ? rcpa_pkg::NEG_LAST_DIGIT_MAX : rcpa_pkg::POS_LAST_DIGIT_MAX;
   assign digit_over = (mag_ff > rcpa_pkg::MAG_LIMIT_DIV10)
                    || ((mag_ff == rcpa_pkg::MAG_LIMIT_DIV10) && (digit > last_max));
   assign signed_scaled = neg_ff ? (64'd0 - scaled_ff) : scaled_ff;
   assign rate_sum = req_current_rate + total_ff - req_applied_so_far;
   assign max_sum  = req_current_max_rate + total_ff - req_applied_so_far;
   assign pos_next = kw_pos_ff + 5'd1;

   always_comb begin
      cand = kw_cand_ff;
      if (cand[0] && !((kw_pos_ff < rcpa_pkg::KW_A_LEN)
                       && (rcpa_pkg::kw_a_char(kw_pos_ff) == ch))) begin
         cand[0] = 1'b0;
      end
      if (cand[1] && !((kw_pos_ff < rcpa_pkg::KW_B_LEN)
                       && (rcpa_pkg::kw_b_char(kw_pos_ff) == ch))) begin
         cand[1] = 1'b0;
      end
   end

   always_comb begin
      line_length_in = line_length_ff;
      phase_in       = phase_ff;
      kw_pos_in      = kw_pos_ff;
      kw_cand_in     = kw_cand_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      scaled_in      = scaled_ff;
      range_err_in   = range_err_ff;
      total_in       = total_ff;
      status_in      = status_ff;
      rate_in        = req_current_rate;
      max_in         = req_current_max_rate;
      applied_in     = req_applied_so_far;
      out_valid_in   = out_valid_ff && !rsp_ready;

      if (accept) begin
         out_valid_in = 1'b1;
         if (req_mode == rcpa_pkg::MODE_BYTE) begin
            if ((ch == rcpa_pkg::CHR_CR) || (ch == rcpa_pkg::CHR_LF)) begin
               if (line_length_ff == '0) begin
                  status_in = rcpa_pkg::ST_IGNORED;
               end else begin
                  if ((phase_ff == rcpa_pkg::PH_KEY) || (phase_ff == rcpa_pkg::PH_UNKNOWN)) begin
                     status_in = rcpa_pkg::ST_UNKNOWN;
                  end else if (((phase_ff == rcpa_pkg::PH_DIGITS)
                                || (phase_ff == rcpa_pkg::PH_TAIL)) && !range_err_ff) begin
                     total_in  = total_ff + signed_scaled;
                     status_in = rcpa_pkg::ST_ACCEPTED;
                  end else begin
                     status_in = rcpa_pkg::ST_INVALID;
                  end
                  line_length_in = '0;
                  phase_in       = rcpa_pkg::PH_KEY;
                  kw_pos_in      = '0;
                  kw_cand_in     = 2'b11;
                  neg_in         = 1'b0;
                  mag_in         = '0;
                  scaled_in      = '0;
                  range_err_in   = 1'b0;
               end
            end else if (ch == rcpa_pkg::CHR_NUL) begin
               status_in = rcpa_pkg::ST_IGNORED;
            end else if (line_length_ff >= LEN_LAST) begin
               line_length_in = '0;
               phase_in       = rcpa_pkg::PH_KEY;
               kw_pos_in      = '0;
               kw_cand_in     = 2'b11;
               neg_in         = 1'b0;
               mag_in         = '0;
               scaled_in      = '0;
               range_err_in   = 1'b0;
               status_in      = rcpa_pkg::ST_OVERFLOW;
            end else begin
               line_length_in = line_length_ff + 1'b1;
               status_in      = rcpa_pkg::ST_KEPT;
               unique case (phase_ff)
                  rcpa_pkg::PH_KEY: begin
                     kw_cand_in = cand;
                     kw_pos_in  = pos_next;
                     if (cand == 2'b00) begin
                        phase_in = rcpa_pkg::PH_UNKNOWN;
                     end else if ((cand[0] && (pos_next == rcpa_pkg::KW_A_LEN))
                                  || (cand[1] && (pos_next == rcpa_pkg::KW_B_LEN))) begin
                        phase_in = rcpa_pkg::PH_BLANK;
                     end
                  end
                  rcpa_pkg::PH_BLANK, rcpa_pkg::PH_SIGN, rcpa_pkg::PH_DIGITS: begin
                     if ((phase_ff == rcpa_pkg::PH_BLANK)
                         && ((ch == rcpa_pkg::CHR_SPACE) || (ch == rcpa_pkg::CHR_TAB)
                             || (ch == rcpa_pkg::CHR_VT) || (ch == rcpa_pkg::CHR_FF))) begin
                        phase_in = rcpa_pkg::PH_BLANK;
                     end else if ((phase_ff == rcpa_pkg::PH_BLANK)
                                  && ((ch == rcpa_pkg::CHR_PLUS)
                                      || (ch == rcpa_pkg::CHR_MINUS))) begin
                        neg_in   = (ch == rcpa_pkg::CHR_MINUS);
                        phase_in = rcpa_pkg::PH_SIGN;
                     end else if (is_digit) begin
                        phase_in = rcpa_pkg::PH_DIGITS;
                        if (!range_err_ff) begin
                           if (digit_over) begin
                              range_err_in = 1'b1;
                           end else begin
                              mag_in    = (mag_ff << 3) + (mag_ff << 1) + 64'(digit);
                              scaled_in = (scaled_ff << 3) + (scaled_ff << 1)
                                        + 64'(14'(digit) * rcpa_pkg::KBPS_SCALE);
                           end
                        end
                     end else if (phase_ff == rcpa_pkg::PH_DIGITS) begin
                        phase_in = rcpa_pkg::PH_TAIL;
                     end else begin
                        phase_in = rcpa_pkg::PH_BAD;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end
         end else if (!req_is_video) begin
            status_in = rcpa_pkg::ST_NOT_VIDEO;
         end else if (total_ff == req_applied_so_far) begin
            status_in = rcpa_pkg::ST_NO_CHANGE;
         end else if (req_current_rate <= 64'sd0) begin
            applied_in = total_ff;
            status_in  = rcpa_pkg::ST_RATE_UNSET;
         end else begin
            rate_in = ($signed(rate_sum) < rcpa_pkg::RATE_FLOOR) ? rcpa_pkg::RATE_FLOOR
                                                                 : rate_sum;
            if (req_current_max_rate > 64'sd0) begin
               max_in = ($signed(max_sum) < rcpa_pkg::RATE_FLOOR) ? rcpa_pkg::RATE_FLOOR
                                                                  : max_sum;
            end
            applied_in = total_ff;
            status_in  = rcpa_pkg::ST_APPLIED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= '0;
         phase_ff       <= rcpa_pkg::PH_KEY;
         kw_pos_ff      <= '0;
         kw_cand_ff     <= 2'b11;
         neg_ff         <= 1'b0;
         mag_ff         <= '0;
         scaled_ff      <= '0;
         range_err_ff   <= 1'b0;
         total_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         line_length_ff <= line_length_in;
         phase_ff       <= phase_in;
         kw_pos_ff      <= kw_pos_in;
         kw_cand_ff     <= kw_cand_in;
         neg_ff         <= neg_in;
         mag_ff         <= mag_in;
         scaled_ff      <= scaled_in;
         range_err_ff   <= range_err_in;
         total_ff       <= total_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= status_in;
         rate_ff    <= rate_in;
         max_ff     <= max_in;
         applied_ff <= applied_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_running_total = total_ff;
   assign rsp_adjusted_rate = rate_ff;
   assign rsp_new_max_rate  = max_ff;
   assign rsp_new_applied   = applied_ff;

   // every taken item leaves a result behind it
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("no result after a taken item");

   // a dropped over-long line leaves the parser empty
   a_overflow_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (status_in == rcpa_pkg::ST_OVERFLOW)) |=>
         ((line_length_ff == '0) && (phase_ff == rcpa_pkg::PH_KEY)))
      else $error("line not cleared after overflow");

   // any phase past keyword start implies at least one byte kept
   a_phase_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != rcpa_pkg::PH_KEY) |-> (line_length_ff != '0))
      else $error("parse phase advanced on an empty line");

   // an update of the record hands back the running total
   a_applied_is_total: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && ((status_ff == rcpa_pkg::ST_APPLIED)
                        || (status_ff == rcpa_pkg::ST_RATE_UNSET)))
         |-> (applied_ff == total_ff))
      else $error("applied record differs from running total");

   // applied rate respects the floor
   a_rate_floor: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (status_ff == rcpa_pkg::ST_APPLIED))
         |-> ($signed(rate_ff) >= rcpa_pkg::RATE_FLOOR))
      else $error("applied rate below floor");

endmodule

[bench/rate_command_parser_accumulator_tb.sv]
`timescale 1ns / 100ps

module rate_command_parser_accumulator_tb;

   localparam int LINE_BYTES = int'(rcpa_pkg::LINE_BUFFER_BYTES_DEFAULT);
   localparam logic [63:0] BPS_PER_KBPS = 64'd1000;
   localparam int RANDOM_ITEMS = 1250;

   // short keyword as text; the long one is a seven-byte prefix followed by it
   localparam logic [8*14-1:0] KW_SHORT_TEXT = "videorateadapt";
   localparam logic [8*7-1:0] KW_PREFIX_TEXT = 56'h73_61_67_65_74_76_5F;

   typedef struct {
      rcpa_pkg::mode_type mode;
      logic [7:0]  ch;
      logic [63:0] rate;
      logic [63:0] max_rate;
      logic [63:0] applied;
      logic        video;
      bit          rel_total;   // applied field is an offset from the running total
      bit          wait_idle;   // hold back until every result is in
   } rate_cmd_type;

   typedef struct {
      rcpa_pkg::status_type status;
      logic [63:0] total;
      logic [63:0] rate;
      logic [63:0] max_rate;
      logic [63:0] applied;
   } rate_result_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_MOSTLY,
      RX_RARELY,
      RX_PERIODIC
   } rx_style_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_mode = 1'b0;
   logic [7:0]         req_char_code = '0;
   logic signed [63:0] req_current_rate = '0;
   logic signed [63:0] req_current_max_rate = '0;
   logic signed [63:0] req_applied_so_far = '0;
   logic               req_is_video = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [3:0]         rsp_status;
   logic signed [63:0] rsp_running_total;
   logic signed [63:0] rsp_adjusted_rate;
   logic signed [63:0] rsp_new_max_rate;
   logic signed [63:0] rsp_new_applied;

   rate_command_parser_accumulator #(
      .LINE_BUFFER_BYTES(LINE_BYTES)
   ) u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_char_code        (req_char_code),
      .req_current_rate     (req_current_rate),
      .req_current_max_rate (req_current_max_rate),
      .req_applied_so_far   (req_applied_so_far),
      .req_is_video         (req_is_video),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_running_total    (rsp_running_total),
      .rsp_adjusted_rate    (rsp_adjusted_rate),
      .rsp_new_max_rate     (rsp_new_max_rate),
      .rsp_new_applied      (rsp_new_applied)
   );

   always #6 clock = ~clock;

   rate_cmd_type    cmd_q[$];
   rate_result_type due_rate_results[$];
   rate_cmd_type    cur_cmd;
   rate_result_type oldest_due;
   int           accepted_count = 0;
   int           results_count = 0;
   int           mismatches = 0;
   int           planned = 0;
   int           gap_left = 0;
   int           burst_left = 0;
   int           status_seen [16];
   rx_style_type rx_style = RX_ALWAYS;
   int           rx_left = 0;

   // line parser and running total as the block should hold them
   int                  line_len;
   rcpa_pkg::phase_type parse_ph;
   logic [4:0]  kw_pos;
   logic [1:0]  kw_cand;
   logic        val_neg;
   logic [63:0] val_mag;
   logic        val_oor;
   logic [63:0] acc_total;

   function automatic logic [7:0] kw_byte(input bit long_kw, input int pos);
      if (long_kw && pos < 7)
         return KW_PREFIX_TEXT[8*(6-pos) +: 8];
      if (long_kw)
         pos = pos - 7;
      if (pos < 0 || pos > 13)
         return rcpa_pkg::CHR_NUL;
      return KW_SHORT_TEXT[8*(13-pos) +: 8];
   endfunction

   function automatic void clear_line_state();
      line_len = 0;
      parse_ph = rcpa_pkg::PH_KEY;
      kw_pos   = '0;
      kw_cand  = 2'b11;
      val_neg  = 1'b0;
      val_mag  = '0;
      val_oor  = 1'b0;
   endfunction

   function automatic void add_kbps_digit(input logic [7:0] ch);
      logic [63:0] d;
      logic [63:0] lim;
      d = {56'd0, ch - rcpa_pkg::CHR_ZERO};
      lim = val_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      if (!val_oor) begin
         if (val_mag > (lim - d) / 64'd10)
            val_oor = 1'b1;
         else
            val_mag = val_mag * 64'd10 + d;
      end
   endfunction

   function automatic void parse_line_byte(input logic [7:0] ch);
      logic [1:0] cand;
      int         pos;
      logic       is_digit;
      is_digit = (ch >= rcpa_pkg::CHR_ZERO && ch <= rcpa_pkg::CHR_NINE);
      case (parse_ph)
         rcpa_pkg::PH_KEY: begin
            cand = kw_cand;
            pos  = kw_pos;
            if (cand[0] && !(pos < rcpa_pkg::KW_A_LEN && kw_byte(1'b0, pos) == ch))
               cand[0] = 1'b0;
            if (cand[1] && !(pos < rcpa_pkg::KW_B_LEN && kw_byte(1'b1, pos) == ch))
               cand[1] = 1'b0;
            pos++;
            kw_cand = cand;
            kw_pos  = pos[4:0];
            if (cand == 2'b00)
               parse_ph = rcpa_pkg::PH_UNKNOWN;
            else if ((cand[0] && pos == rcpa_pkg::KW_A_LEN)
                     || (cand[1] && pos == rcpa_pkg::KW_B_LEN))
               parse_ph = rcpa_pkg::PH_BLANK;
         end
         rcpa_pkg::PH_BLANK: begin
            if (!(ch == rcpa_pkg::CHR_SPACE || ch == rcpa_pkg::CHR_TAB
                  || ch == rcpa_pkg::CHR_VT || ch == rcpa_pkg::CHR_FF)) begin
               if (ch == rcpa_pkg::CHR_PLUS || ch == rcpa_pkg::CHR_MINUS) begin
                  val_neg  = (ch == rcpa_pkg::CHR_MINUS);
                  parse_ph = rcpa_pkg::PH_SIGN;
               end else if (is_digit) begin
                  parse_ph = rcpa_pkg::PH_DIGITS;
                  add_kbps_digit(ch);
               end else begin
                  parse_ph = rcpa_pkg::PH_BAD;
               end
            end
         end
         rcpa_pkg::PH_SIGN: begin
            if (is_digit) begin
               parse_ph = rcpa_pkg::PH_DIGITS;
               add_kbps_digit(ch);
            end else begin
               parse_ph = rcpa_pkg::PH_BAD;
            end
         end
         rcpa_pkg::PH_DIGITS: begin
            if (is_digit)
               add_kbps_digit(ch);
            else
               parse_ph = rcpa_pkg::PH_TAIL;
         end
         default: ;
      endcase
   endfunction

   function automatic rcpa_pkg::status_type finish_line();
      rcpa_pkg::status_type st;
      if (parse_ph == rcpa_pkg::PH_KEY || parse_ph == rcpa_pkg::PH_UNKNOWN) begin
         st = rcpa_pkg::ST_UNKNOWN;
      end else if ((parse_ph == rcpa_pkg::PH_DIGITS || parse_ph == rcpa_pkg::PH_TAIL)
                   && !val_oor) begin
         acc_total = acc_total + (val_neg ? -val_mag : val_mag) * BPS_PER_KBPS;
         st = rcpa_pkg::ST_ACCEPTED;
      end else begin
         st = rcpa_pkg::ST_INVALID;
      end
      clear_line_state();
      return st;
   endfunction

   function automatic rate_result_type step_rate_model(input rate_cmd_type c);
      rate_result_type r;
      logic [63:0]  delta;
      logic [63:0]  sum;
      r.status   = rcpa_pkg::ST_KEPT;
      r.rate     = c.rate;
      r.max_rate = c.max_rate;
      r.applied  = c.applied;
      if (c.mode == rcpa_pkg::MODE_BYTE) begin
         if (c.ch == rcpa_pkg::CHR_CR || c.ch == rcpa_pkg::CHR_LF) begin
            r.status = (line_len == 0) ? rcpa_pkg::ST_IGNORED : finish_line();
         end else if (c.ch == rcpa_pkg::CHR_NUL) begin
            r.status = rcpa_pkg::ST_IGNORED;
         end else if (line_len + 1 >= LINE_BYTES) begin
            clear_line_state();
            r.status = rcpa_pkg::ST_OVERFLOW;
         end else begin
            line_len++;
            parse_line_byte(c.ch);
         end
      end else if (!c.video) begin
         r.status = rcpa_pkg::ST_NOT_VIDEO;
      end else begin
         delta = acc_total - c.applied;
         if (delta == 0) begin
            r.status = rcpa_pkg::ST_NO_CHANGE;
         end else if ($signed(c.rate) <= 0) begin
            r.applied = acc_total;
            r.status  = rcpa_pkg::ST_RATE_UNSET;
         end else begin
            sum = c.rate + delta;
            if ($signed(sum) < rcpa_pkg::RATE_FLOOR)
               sum = rcpa_pkg::RATE_FLOOR;
            r.rate = sum;
            if ($signed(c.max_rate) > 0) begin
               sum = c.max_rate + delta;
               if ($signed(sum) < rcpa_pkg::RATE_FLOOR)
                  sum = rcpa_pkg::RATE_FLOOR;
               r.max_rate = sum;
            end
            r.applied = acc_total;
            r.status  = rcpa_pkg::ST_APPLIED;
         end
      end
      r.total = acc_total;
      return r;
   endfunction

   // ---------------- stimulus helpers ----------------

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_rate();
      logic [63:0] v;
      v = rand64();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return {1'b1, v[62:0]};
         2: return 64'($urandom_range(1, 5000));
         3: return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000000));
         4: return {1'b0, v[62:0]};
         default: return v;
      endcase
   endfunction

   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(1, 255));
      while (b == rcpa_pkg::CHR_CR || b == rcpa_pkg::CHR_LF);
      return b;
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 3))
         0: return rcpa_pkg::CHR_SPACE;
         1: return rcpa_pkg::CHR_TAB;
         2: return rcpa_pkg::CHR_VT;
         default: return rcpa_pkg::CHR_FF;
      endcase
   endfunction

   function automatic logic [7:0] pick_eol();
      return $urandom_range(0, 1) ? rcpa_pkg::CHR_CR : rcpa_pkg::CHR_LF;
   endfunction

   function automatic string value_text();
      logic [63:0] v;
      v = rand64();
      case ($urandom_range(0, 10))
         0, 1, 2: return $sformatf("%0d", $urandom_range(0, 99999));
         3: return $sformatf("%0d", 64'h7FFF_FFFF_FFFF_FFFF);
         4: return $sformatf("%0d", 64'h8000_0000_0000_0000);
         5: return $sformatf("%0d", 64'h8000_0000_0000_0001);
         6, 7: return $sformatf("%0d", v);
         8: return {"000", $sformatf("%0d", $urandom_range(0, 999))};
         9: return "123456789012345678901234";
         default: return $sformatf("922337203685477580%0d", $urandom_range(0, 9));
      endcase
   endfunction

   task automatic push_byte(input logic [7:0] ch);
      rate_cmd_type c;
      c.mode      = rcpa_pkg::MODE_BYTE;
      c.ch        = ch;
      c.rate      = rand64();
      c.max_rate  = rand64();
      c.applied   = rand64();
      c.video     = 1'($urandom_range(0, 1));
      c.rel_total = 1'b0;
      c.wait_idle = 1'b0;
      cmd_q.push_back(c);
      if (ch != rcpa_pkg::CHR_NUL)
         planned++;
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         push_byte(s[i]);
   endtask

   task automatic push_keyword(input bit long_kw, input int upto);
      int i;
      for (i = 0; i < upto; i++)
         push_byte(kw_byte(long_kw, i));
   endtask

   task automatic push_rate_apply(input logic video, input logic [63:0] rate,
                                  input logic [63:0] max_rate, input bit rel_total,
                                  input logic [63:0] applied, input bit wait_idle);
      rate_cmd_type c;
      c.mode      = rcpa_pkg::MODE_APPLY;
      c.ch        = 8'($urandom);
      c.rate      = rate;
      c.max_rate  = max_rate;
      c.applied   = applied;
      c.video     = video;
      c.rel_total = rel_total;
      c.wait_idle = wait_idle;
      cmd_q.push_back(c);
      planned++;
   endtask

   task automatic push_random_apply();
      logic [63:0] offs;
      bit          rel;
      rel = 1'b1;
      case ($urandom_range(0, 3))
         0: offs = '0;
         1, 2: offs = $urandom_range(0, 1) ?
                      64'($urandom_range(0, 4000000)) - 64'd2000000 : rand64();
         default: begin
            rel  = 1'b0;
            offs = rand64();
         end
      endcase
      push_rate_apply($urandom_range(0, 9) != 0, pick_rate(), pick_rate(), rel, offs,
                      $urandom_range(0, 29) == 0);
   endtask

   task automatic push_rate_line();
      bit long_kw;
      int sign_pick;
      long_kw = 1'($urandom_range(0, 1));
      push_keyword(long_kw, int'(long_kw ? rcpa_pkg::KW_B_LEN : rcpa_pkg::KW_A_LEN));
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : $urandom_range(0, 1))
         push_byte(pick_blank());
      sign_pick = $urandom_range(0, 2);
      if (sign_pick == 1)
         push_byte(rcpa_pkg::CHR_PLUS);
      else if (sign_pick == 2)
         push_byte(rcpa_pkg::CHR_MINUS);
      if ($urandom_range(0, 19) == 0)
         push_byte(rcpa_pkg::CHR_NUL);
      push_text(value_text());
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) push_byte(stray_byte());
      push_byte(pick_eol());
   endtask

   task automatic push_broken_line();
      bit long_kw;
      int len;
      int bad;
      int i;
      long_kw = 1'($urandom_range(0, 1));
      len = int'(long_kw ? rcpa_pkg::KW_B_LEN : rcpa_pkg::KW_A_LEN);
      case ($urandom_range(0, 5))
         0: begin
            bad = $urandom_range(0, len - 1);
            for (i = 0; i < len; i++)
               push_byte(i == bad ? stray_byte() : kw_byte(long_kw, i));
            push_byte(rcpa_pkg::CHR_SPACE);
            push_text("42");
         end
         1: push_keyword(long_kw, $urandom_range(1, len - 1));
         2: begin
            push_keyword(long_kw, len);
            push_byte(pick_blank());
         end
         3: begin
            push_keyword(long_kw, len);
            push_byte(rcpa_pkg::CHR_MINUS);
            push_byte(stray_byte());
            push_text("17");
         end
         4: begin
            push_keyword(long_kw, len);
            push_byte(stray_byte());
            push_text("5");
         end
         default: repeat ($urandom_range(1, 8)) push_byte(stray_byte());
      endcase
      push_byte(pick_eol());
   endtask

   task automatic report_field(input string what, input logic [63:0] want,
                               input logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
      end
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_line_state();
         acc_total  = '0;
         gap_left   = 0;
         burst_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            due_rate_results.push_back(step_rate_model(cur_cmd));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_q.size() != 0 &&
                         !(cmd_q[0].wait_idle && accepted_count != results_count)) begin
               cur_cmd = cmd_q.pop_front();
               // the total is up to date here, so exact and near records can be built
               if (cur_cmd.rel_total)
                  cur_cmd.applied = acc_total + cur_cmd.applied;
               burst_left--;
               req_valid            <= 1'b1;
               req_mode             <= cur_cmd.mode;
               req_char_code        <= cur_cmd.ch;
               req_current_rate     <= cur_cmd.rate;
               req_current_max_rate <= cur_cmd.max_rate;
               req_applied_so_far   <= cur_cmd.applied;
               req_is_video         <= cur_cmd.video;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- receiver ----------------

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_style = rx_style_type'($urandom_range(0, 3));
         rx_left  = $urandom_range(16, 96);
      end
      rx_left--;
      case (rx_style)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_MOSTLY:   rsp_ready <= ($urandom_range(0, 3) != 0);
         RX_RARELY:   rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= (rx_left[1:0] != 2'd0);
      endcase
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_count <= results_count + 1;
         if (due_rate_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, expected nothing actual status %0d",
                     $time, rsp_status);
         end else begin
            oldest_due = due_rate_results.pop_front();
            status_seen[oldest_due.status]++;
            report_field("status", 64'(oldest_due.status), 64'(rsp_status));
            report_field("running_total", oldest_due.total, rsp_running_total);
            report_field("adjusted_rate", oldest_due.rate, rsp_adjusted_rate);
            report_field("new_max_rate", oldest_due.max_rate, rsp_new_max_rate);
            report_field("new_applied", oldest_due.applied, rsp_new_applied);
         end
      end
   end

   // ---------------- stimulus and end of run ----------------

   initial begin
      int pick;
      int i;

      // idle line, apply outcomes from a zero total, stray bytes, a negative line, its apply
      push_rate_apply(1'b1, 64'd5000, 64'd8000, 1'b1, 64'd0, 1'b0);
      push_rate_apply(1'b0, 64'd5000, 64'd8000, 1'b0, 64'd3, 1'b0);
      push_byte(rcpa_pkg::CHR_LF);
      push_byte(rcpa_pkg::CHR_NUL);
      push_rate_apply(1'b1, 64'd0, 64'd0, 1'b0, 64'd7, 1'b0);
      push_rate_apply(1'b1, 64'd1500, 64'd2000, 1'b0, 64'd4000, 1'b0);
      push_rate_apply(1'b1, 64'h7FFF_FFFF_FFFF_FF00, 64'h8000_0000_0000_0000, 1'b0,
                      64'hFFFF_FFFF_FFFF_F000, 1'b0);
      push_text("x\r");
      push_keyword(1'b0, int'(rcpa_pkg::KW_A_LEN));
      push_text(" -12\n");
      push_rate_apply(1'b1, 64'd90000, 64'd120000, 1'b1, 64'd0, 1'b1);

      // longest line that still fits, then one that runs over
      push_keyword(1'b0, int'(rcpa_pkg::KW_A_LEN));
      for (i = 0; i < LINE_BYTES - 2 - int'(rcpa_pkg::KW_A_LEN); i++)
         push_byte(rcpa_pkg::CHR_SPACE);
      push_text("7\n");
      push_keyword(1'b1, int'(rcpa_pkg::KW_B_LEN));
      for (i = 0; i < LINE_BYTES - 1 - int'(rcpa_pkg::KW_B_LEN); i++)
         push_byte(rcpa_pkg::CHR_SPACE);
      push_text("34\r");
      push_rate_apply(1'b1, 64'd1000000, 64'd2000000, 1'b0, 64'd0, 1'b1);

      while (planned < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            push_rate_line();
         else if (pick < 62)
            push_broken_line();
         else if (pick < 92)
            push_random_apply();
         else if (pick < 96)
            push_byte(8'($urandom));
         else
            push_byte($urandom_range(0, 1) ? rcpa_pkg::CHR_NUL : pick_eol());
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || req_valid)
         @(posedge clock);
      while (results_count != accepted_count)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (due_rate_results.size() != 0) begin
         mismatches++;
         $display("%0t: results outstanding, expected 0 actual %0d",
                  $time, due_rate_results.size());
      end

      $display("sent %0d command and apply items, checked %0d results, %0d mismatches",
               accepted_count, results_count, mismatches);
      $display({"outcomes: kept %0d, ignored %0d, accepted %0d, unknown %0d, invalid %0d, ",
                "too long %0d, not video %0d, unchanged %0d, rate unset %0d, applied %0d"},
               status_seen[rcpa_pkg::ST_KEPT], status_seen[rcpa_pkg::ST_IGNORED],
               status_seen[rcpa_pkg::ST_ACCEPTED], status_seen[rcpa_pkg::ST_UNKNOWN],
               status_seen[rcpa_pkg::ST_INVALID], status_seen[rcpa_pkg::ST_OVERFLOW],
               status_seen[rcpa_pkg::ST_NOT_VIDEO], status_seen[rcpa_pkg::ST_NO_CHANGE],
               status_seen[rcpa_pkg::ST_RATE_UNSET], status_seen[rcpa_pkg::ST_APPLIED]);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
